// ===== design/rmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 median filter package
// Beat types, sorted column types and the compare network functions used by
// the filter datapath and its output queue.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int CHANNELS    = 3;
    localparam int Q_DEPTH     = 3;
    localparam int CNT_BITS    = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] STALL_LEVEL = CNT_BITS'(Q_DEPTH - 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [2:0]          t_triple;
    typedef t_triple [CHANNELS-1:0] t_column;

    typedef struct packed {
        t_sample top_red;
        t_sample top_green;
        t_sample top_blue;
        t_sample mid_red;
        t_sample mid_green;
        t_sample mid_blue;
        t_sample bot_red;
        t_sample bot_green;
        t_sample bot_blue;
        logic    row_end;
    } t_in_beat;

    typedef struct packed {
        t_sample out_red;
        t_sample out_green;
        t_sample out_blue;
        logic    run_last;
        logic    pixel_row_last;
    } t_out_beat;

    function automatic t_sample min2(input t_sample a, input t_sample b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_sample max2(input t_sample a, input t_sample b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_sample med3(input t_sample a, input t_sample b, input t_sample c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Ascending order: element 0 is the minimum.
    function automatic t_triple sort3(input t_sample a, input t_sample b, input t_sample c);
        t_triple dst;
        dst[0] = min2(min2(a, b), c);
        dst[1] = med3(a, b, c);
        dst[2] = max2(max2(a, b), c);
        return dst;
    endfunction

    function automatic t_sample median9(input t_triple l, input t_triple m, input t_triple r);
        t_sample lo;
        t_sample md;
        t_sample hi;
        lo = max2(max2(l[0], m[0]), r[0]);
        md = med3(l[1], m[1], r[1]);
        hi = min2(min2(l[2], m[2]), r[2]);
        return med3(lo, md, hi);
    endfunction

endpackage
`default_nettype wire

// ===== design/rgb_median_filter_3x3_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 median filter
// The block takes one image column of three vertically adjacent RGB pixels
// per beat and returns the exact 3x3 median of each channel, with zero
// columns at the left and right edges of a row. It accepts one column every
// clock cycle while the input is not stalled. The first column of a row
// gives no pixel, every later column gives the pixel centered on the column
// before it, and the column marked row_end also gives the pixel centered on
// itself. Results pass through a registered output queue; the input stalls
// only while the three-entry output queue holds two or more results.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rmf_pkg::t_in_beat   i_in_beat,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output rmf_pkg::t_out_beat       o_out_beat
);

    rmf_pkg::t_column             r_col0;
    rmf_pkg::t_column             r_col1;
    logic                         r_open;
    rmf_pkg::t_column             w_cur;
    rmf_pkg::t_column             w_left_b;
    rmf_pkg::t_sample [2:0]       w_med_a;
    rmf_pkg::t_sample [2:0]       w_med_b;
    rmf_pkg::t_out_beat           w_beat_a;
    rmf_pkg::t_out_beat           w_beat_b;
    rmf_pkg::t_out_beat           w_push_data0;
    logic [1:0]                   w_push_cnt;
    logic                         w_accept;
    logic                         w_pop;
    logic [rmf_pkg::CNT_BITS-1:0] w_cnt;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_pop    = o_out_valid && !i_out_stall;

    always_comb begin
        w_cur[0] = rmf_pkg::sort3(i_in_beat.top_red, i_in_beat.mid_red, i_in_beat.bot_red);
        w_cur[1] = rmf_pkg::sort3(i_in_beat.top_green, i_in_beat.mid_green,
                                  i_in_beat.bot_green);
        w_cur[2] = rmf_pkg::sort3(i_in_beat.top_blue, i_in_beat.mid_blue, i_in_beat.bot_blue);
        w_left_b = r_open ? r_col1 : '0;
        for (int ch = 0; ch < rmf_pkg::CHANNELS; ch++) begin
            w_med_a[ch] = rmf_pkg::median9(r_col0[ch], r_col1[ch], w_cur[ch]);
            w_med_b[ch] = rmf_pkg::median9(w_left_b[ch], w_cur[ch], '0);
        end
    end

    always_comb begin
        w_beat_a.out_red        = w_med_a[0];
        w_beat_a.out_green      = w_med_a[1];
        w_beat_a.out_blue       = w_med_a[2];
        w_beat_a.run_last       = !i_in_beat.row_end;
        w_beat_a.pixel_row_last = 1'b0;
        w_beat_b.out_red        = w_med_b[0];
        w_beat_b.out_green      = w_med_b[1];
        w_beat_b.out_blue       = w_med_b[2];
        w_beat_b.run_last       = 1'b1;
        w_beat_b.pixel_row_last = 1'b1;
        w_push_data0            = r_open ? w_beat_a : w_beat_b;
        w_push_cnt              = w_accept ? ({1'b0, r_open} + {1'b0, i_in_beat.row_end})
                                           : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col0 <= w_left_b;
            r_col1 <= w_cur;
        end
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (w_accept) begin
            r_open <= !i_in_beat.row_end;
        end
    end

    rmf_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (w_push_cnt),
        .i_push_data0 (w_push_data0),
        .i_push_data1 (w_beat_b),
        .i_pop        (w_pop),
        .o_head       (o_out_beat),
        .o_cnt        (w_cnt)
    );

    assign o_out_valid = (w_cnt != '0);
    assign o_in_stall  = (w_cnt >= rmf_pkg::STALL_LEVEL);

endmodule
`default_nettype wire

// ===== design/rmf_out_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 median filter output queue
// Three-entry shifting queue that takes up to two result beats per cycle
// and presents the oldest one at its head.
// ----------------------------------------------------------------------------
module rmf_out_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [1:0]                    i_push_cnt,
    input  wire rmf_pkg::t_out_beat            i_push_data0,
    input  wire rmf_pkg::t_out_beat            i_push_data1,
    input  wire logic                          i_pop,
    output rmf_pkg::t_out_beat                 o_head,
    output logic [rmf_pkg::CNT_BITS-1:0]       o_cnt
);

    rmf_pkg::t_out_beat [rmf_pkg::Q_DEPTH-1:0] r_q;
    rmf_pkg::t_out_beat [rmf_pkg::Q_DEPTH-1:0] n_q;
    rmf_pkg::t_out_beat [rmf_pkg::Q_DEPTH-1:0] w_shift;
    logic [rmf_pkg::CNT_BITS-1:0]              r_cnt;
    logic [rmf_pkg::CNT_BITS-1:0]              n_cnt;
    logic [rmf_pkg::CNT_BITS-1:0]              w_base;

    always_comb begin
        w_base  = r_cnt - rmf_pkg::CNT_BITS'(i_pop);
        w_shift = r_q >> $bits(rmf_pkg::t_out_beat);
        for (int k = 0; k < rmf_pkg::Q_DEPTH; k++) begin
            if (rmf_pkg::CNT_BITS'(k) < w_base) begin
                n_q[k] = i_pop ? w_shift[k] : r_q[k];
            end else if (rmf_pkg::CNT_BITS'(k) == w_base) begin
                n_q[k] = i_push_data0;
            end else begin
                n_q[k] = i_push_data1;
            end
        end
        n_cnt = w_base + rmf_pkg::CNT_BITS'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head = r_q[0];
    assign o_cnt  = r_cnt;

endmodule
`default_nettype wire

// ===== design/rmf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 median filter port checker
// Checks the filter's handshake and result flags as seen on its ports.
// ----------------------------------------------------------------------------
module rmf_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_stall,
    input  wire rmf_pkg::t_in_beat   i_in_beat,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire rmf_pkg::t_out_beat  o_out_beat
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_row_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.pixel_row_last |-> o_out_beat.run_last)
        else $error("row end pixel without run_last");

    a_out_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("output beat appeared without an accepted input beat");

    a_row_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_beat.row_end && o_out_valid && i_out_stall
        |=> o_in_stall)
        else $error("input not stalled while two results wait behind a held beat");

endmodule

bind rgb_median_filter_3x3_top rmf_checker u_rmf_checker (.*);
`default_nettype wire
